[hdl/cpp_pkg.sv]
`default_nettype none

package cpp_pkg;

   // Saturation bound of all internal Q.24 values: +-(2^62-1)
   localparam logic signed [63:0] QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   // 1.0 in Q8.24
   localparam logic signed [63:0] Q24_ONE = 64'sd16777216;
   // quotient bits produced by the divider, one per stage
   localparam int unsigned DIV_STEPS = 56;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_FOCAL     = 3'd0,
      CSR_PRINCIPAL = 3'd1,
      CSR_K1        = 3'd2,
      CSR_K2        = 3'd3,
      CSR_K3        = 3'd4,
      CSR_P1        = 3'd5,
      CSR_P2        = 3'd6,
      CSR_FOV       = 3'd7
   } csr_index_type;

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > QLIM) r = QLIM;
      if (v < -QLIM) r = -QLIM;
      return r;
   endfunction

   // saturating add; both clamped operands fit, so the raw sum cannot wrap
   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] s;
      s = clamp(a) + clamp(b);
      return clamp(s);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      r = v[31:0];
      if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) r = 32'sh8000_0000;
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/cpp_delay.sv]
`default_nettype none

module cpp_delay #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] d,
   output logic      [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // plain shift line, advances with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < int'(DEPTH); i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

[hdl/cpp_qmul.sv]
`default_nettype none

// Q.24 product: sign * floor(|a|*|b| / 2^24), saturated.
module cpp_qmul import cpp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [63:0] a,
   input  wire logic signed [63:0] b,
   output logic signed      [63:0] p
);

   logic signed [63:0] ca, cb;
   logic        [61:0] ua_in, ub_in;
   logic        [61:0] ua_ff, ub_ff;
   logic               neg1_ff, neg2_ff;
   logic        [63:0] pp_ll_ff;
   logic        [61:0] pp_lh_ff, pp_hl_ff;
   logic        [59:0] pp_hh_ff;
   logic       [123:0] prod;
   logic        [99:0] qm;
   logic        [61:0] m;
   logic signed [63:0] p_in;
   logic signed [63:0] p_ff;

   // stage 1: clamp, split into sign and magnitude
   always_comb begin
      ca = clamp(a);
      cb = clamp(b);
      ua_in = ca[63] ? 62'(-ca) : ca[61:0];
      ub_in = cb[63] ? 62'(-cb) : cb[61:0];
   end

   // stage 3: sum partials, scale, saturate, restore sign
   always_comb begin
      prod = 124'(pp_ll_ff) + (124'(pp_lh_ff) << 32) + (124'(pp_hl_ff) << 32)
           + (124'(pp_hh_ff) << 64);
      qm = prod[123:24];
      m = (qm > 100'(QLIM)) ? QLIM[61:0] : qm[61:0];
      p_in = neg2_ff ? -$signed({2'b00, m}) : $signed({2'b00, m});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff    <= ua_in;
         ub_ff    <= ub_in;
         neg1_ff  <= ca[63] ^ cb[63];
         // stage 2: four partials of the 32/30-bit magnitude halves
         pp_ll_ff <= ua_ff[31:0] * ub_ff[31:0];
         pp_lh_ff <= ua_ff[31:0] * ub_ff[61:32];
         pp_hl_ff <= ua_ff[61:32] * ub_ff[31:0];
         pp_hh_ff <= ua_ff[61:32] * ub_ff[61:32];
         neg2_ff  <= neg1_ff;
         p_ff     <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

[hdl/cpp_div.sv]
`default_nettype none

// num * 2^24 / den, truncated toward zero, saturated to 32 bits; zero den gives 0.
// Restoring divider, one quotient bit per stage.
module cpp_div import cpp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic signed      [31:0] quo
);

   logic [DIV_STEPS-1:0] work_ff [DIV_STEPS+1];
   logic [31:0]          rem_ff  [DIV_STEPS+1];
   logic [31:0]          den_ff  [DIV_STEPS+1];
   logic                 neg_ff  [DIV_STEPS+1];
   logic                 zero_ff [DIV_STEPS+1];
   logic [31:0]          num_mag, den_mag;
   logic [DIV_STEPS-1:0] q;
   logic signed [31:0]   quo_in;
   logic signed [31:0]   quo_ff;

   assign num_mag = num[31] ? 32'(-num) : num;
   assign den_mag = den[31] ? 32'(-den) : den;

   // operand setup
   always_ff @(posedge clock) begin
      if (en) begin
         work_ff[0] <= DIV_STEPS'({num_mag, 24'b0});
         rem_ff[0]  <= '0;
         den_ff[0]  <= den_mag;
         neg_ff[0]  <= num[31] ^ den[31];
         zero_ff[0] <= (den == '0);
      end
   end

   // one quotient bit per stage
   for (genvar s = 0; s < int'(DIV_STEPS); s++) begin : g_step
      logic [32:0] trial, diff;
      logic        ge;
      always_comb begin
         trial = {rem_ff[s], work_ff[s][DIV_STEPS-1]};
         diff  = trial - {1'b0, den_ff[s]};
         ge    = (trial >= {1'b0, den_ff[s]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1]  <= ge ? diff[31:0] : trial[31:0];
            work_ff[s+1] <= {work_ff[s][DIV_STEPS-2:0], ge};
            den_ff[s+1]  <= den_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
         end
      end
   end

   // sign and saturation
   always_comb begin
      q = work_ff[DIV_STEPS];
      if (zero_ff[DIV_STEPS]) begin
         quo_in = '0;
      end else if (!neg_ff[DIV_STEPS]) begin
         quo_in = (q > DIV_STEPS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      end else begin
         quo_in = (q > DIV_STEPS'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

[hdl/cpp_fov.sv]
`default_nettype none

// Exact field-of-view test: valid when z > 0 and, unless the limit is all ones,
// (x^2+y^2)*2^16 <= limit*z^2.
module cpp_fov (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] x,
   input  wire logic signed [31:0] y,
   input  wire logic signed [31:0] z,
   input  wire logic        [31:0] limit,
   output logic                    ok
);

   logic [31:0] ax, ay, az;
   logic [63:0] ax2_ff, ay2_ff, az2_ff;
   logic        pos1_ff, pos2_ff, dis1_ff, dis2_ff;
   logic [63:0] s_ff, m_lo_ff, m_hi_ff;
   logic [95:0] rhs, lhs;
   logic        ok_ff;

   assign ax = x[31] ? 32'(-x) : x;
   assign ay = y[31] ? 32'(-y) : y;
   assign az = z[31] ? 32'(-z) : z;

   always_comb begin
      rhs = {m_hi_ff, 32'b0} + 96'(m_lo_ff);
      lhs = 96'({s_ff, 16'b0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // squares
         ax2_ff  <= ax * ax;
         ay2_ff  <= ay * ay;
         az2_ff  <= az * az;
         pos1_ff <= !z[31] && (z != '0);
         dis1_ff <= (limit == '1);
         // radius sum and limit times depth squared, in halves
         s_ff    <= ax2_ff + ay2_ff;
         m_lo_ff <= limit * az2_ff[31:0];
         m_hi_ff <= limit * az2_ff[63:32];
         pos2_ff <= pos1_ff;
         dis2_ff <= dis1_ff;
         // compare
         ok_ff   <= pos2_ff && (dis2_ff || !(lhs > rhs));
      end
   end

   assign ok = ok_ff;

endmodule

`default_nettype wire

[hdl/camera_point_projection_core.sv]
`default_nettype none

// Channel  | Dir | Payload
// req_     | in  | tdata: point_x [31:0], point_y [63:32], point_z [95:64]
// rsp_     | out | tdata: pixel_x [31:0], pixel_y [63:32]; tuser: valid_res
// csr_     | in  | csr_index register number, csr_data value, always ready
//
// One point is accepted every cycle unless a finished result is stalled. The latency
// from accept to result is set by the 56-stage bit-per-stage divider plus the chain of
// dependent Q.24 multipliers for r^2, r^4, r^6 and the distortion.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and loads the register defaults.
module camera_point_projection_core import cpp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // point_x, point_y, point_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [63:0] rsp_tdata,   // pixel_x, pixel_y
   output logic      [0:0]  rsp_tuser,   // valid_res
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int unsigned LAT     = 81;
   localparam int unsigned FOV_LAT = 3;

   logic [63:0]        focal_ff, principal_ff;
   logic signed [31:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   logic [31:0]        fov_ff;
   logic               vld_ff [LAT];
   logic               en;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff     <= 64'h0001_0000_0001_0000;
         principal_ff <= '0;
         k1_ff        <= '0;
         k2_ff        <= '0;
         k3_ff        <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         fov_ff       <= '1;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FOCAL:     focal_ff     <= csr_data;
            CSR_PRINCIPAL: principal_ff <= csr_data;
            CSR_K1:        k1_ff        <= csr_data[31:0];
            CSR_K2:        k2_ff        <= csr_data[31:0];
            CSR_K3:        k3_ff        <= csr_data[31:0];
            CSR_P1:        p1_ff        <= csr_data[31:0];
            CSR_P2:        p2_ff        <= csr_data[31:0];
            CSR_FOV:       fov_ff       <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // global advance: the pipeline moves unless a finished result is held
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(LAT); i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < int'(LAT); i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // configuration operands
   logic signed [63:0] k1, k2, k3, p1, p2, p1x2, p2x2, fx, fy, cx, cy;
   assign k1   = {{32{k1_ff[31]}}, k1_ff};
   assign k2   = {{32{k2_ff[31]}}, k2_ff};
   assign k3   = {{32{k3_ff[31]}}, k3_ff};
   assign p1   = {{32{p1_ff[31]}}, p1_ff};
   assign p2   = {{32{p2_ff[31]}}, p2_ff};
   assign p1x2 = {{31{p1_ff[31]}}, p1_ff, 1'b0};
   assign p2x2 = {{31{p2_ff[31]}}, p2_ff, 1'b0};
   assign fx   = {32'b0, focal_ff[63:32]};
   assign fy   = {32'b0, focal_ff[31:0]};
   assign cx   = {{32{principal_ff[63]}}, principal_ff[63:32]};
   assign cy   = {{32{principal_ff[31]}}, principal_ff[31:0]};

   // field-of-view test, flag carried to the output stage
   logic fov_ok, fov_ok_d;

   cpp_fov u_fov (
      .clock (clock),
      .en    (en),
      .x     (req_tdata[31:0]),
      .y     (req_tdata[63:32]),
      .z     (req_tdata[95:64]),
      .limit (fov_ff),
      .ok    (fov_ok)
   );

   cpp_delay #(.WIDTH(1), .DEPTH(LAT - FOV_LAT - 1)) u_fov_dly (
      .clock (clock), .en (en), .d (fov_ok), .q (fov_ok_d)
   );

   // normalization
   logic signed [31:0] xq, yq;
   logic signed [63:0] xn, yn;

   cpp_div u_div_x (
      .clock (clock), .en (en),
      .num (req_tdata[31:0]), .den (req_tdata[95:64]), .quo (xq)
   );
   cpp_div u_div_y (
      .clock (clock), .en (en),
      .num (req_tdata[63:32]), .den (req_tdata[95:64]), .quo (yq)
   );

   assign xn = {{32{xq[31]}}, xq};
   assign yn = {{32{yq[31]}}, yq};

   // squares and cross term
   logic signed [63:0] x2, y2, xy;
   cpp_qmul u_x2 (.clock(clock), .en(en), .a(xn), .b(xn), .p(x2));
   cpp_qmul u_y2 (.clock(clock), .en(en), .a(yn), .b(yn), .p(y2));
   cpp_qmul u_xy (.clock(clock), .en(en), .a(xn), .b(yn), .p(xy));

   logic signed [63:0] r2_ff, tx2_ff, ty2_ff, ux_ff, uy_ff;
   logic signed [63:0] r2_d, r4, r6, k1r2, k2r4, k2r4_d, k3r6;
   logic signed [63:0] s1_ff, s1_d, s2_ff, rf_ff;
   logic signed [63:0] p1xy, p1xy_d, p2xy, p2xy_d, p2ux, p1uy;
   logic signed [63:0] xt_ff, yt_ff, xt_d, yt_d;
   logic signed [63:0] xn_d, yn_d, xnrf, ynrf, xd_ff, yd_ff, fxxd, fyyd;
   logic signed [31:0] px_ff, py_ff;
   logic               ok_ff;

   // radius powers
   cpp_qmul u_r4   (.clock(clock), .en(en), .a(r2_ff), .b(r2_ff), .p(r4));
   cpp_qmul u_k1r2 (.clock(clock), .en(en), .a(k1),    .b(r2_ff), .p(k1r2));
   cpp_delay #(.WIDTH(64), .DEPTH(3)) u_r2_dly (
      .clock (clock), .en (en), .d (r2_ff), .q (r2_d)
   );
   cpp_qmul u_r6   (.clock(clock), .en(en), .a(r4), .b(r2_d), .p(r6));
   cpp_qmul u_k2r4 (.clock(clock), .en(en), .a(k2), .b(r4),   .p(k2r4));
   cpp_qmul u_k3r6 (.clock(clock), .en(en), .a(k3), .b(r6),   .p(k3r6));

   cpp_delay #(.WIDTH(64), .DEPTH(6)) u_s1_dly (
      .clock (clock), .en (en), .d (s1_ff), .q (s1_d)
   );
   cpp_delay #(.WIDTH(64), .DEPTH(3)) u_k2r4_dly (
      .clock (clock), .en (en), .d (k2r4), .q (k2r4_d)
   );

   // tangential terms
   cpp_qmul u_p1xy (.clock(clock), .en(en), .a(p1x2), .b(xy),    .p(p1xy));
   cpp_qmul u_p2xy (.clock(clock), .en(en), .a(p2x2), .b(xy),    .p(p2xy));
   cpp_qmul u_p2ux (.clock(clock), .en(en), .a(p2),   .b(ux_ff), .p(p2ux));
   cpp_qmul u_p1uy (.clock(clock), .en(en), .a(p1),   .b(uy_ff), .p(p1uy));
   cpp_delay #(.WIDTH(64), .DEPTH(2)) u_p1xy_dly (
      .clock (clock), .en (en), .d (p1xy), .q (p1xy_d)
   );
   cpp_delay #(.WIDTH(64), .DEPTH(2)) u_p2xy_dly (
      .clock (clock), .en (en), .d (p2xy), .q (p2xy_d)
   );
   cpp_delay #(.WIDTH(64), .DEPTH(9)) u_xt_dly (
      .clock (clock), .en (en), .d (xt_ff), .q (xt_d)
   );
   cpp_delay #(.WIDTH(64), .DEPTH(9)) u_yt_dly (
      .clock (clock), .en (en), .d (yt_ff), .q (yt_d)
   );

   // radial scaling of the normalized point
   cpp_delay #(.WIDTH(64), .DEPTH(15)) u_xn_dly (
      .clock (clock), .en (en), .d (xn), .q (xn_d)
   );
   cpp_delay #(.WIDTH(64), .DEPTH(15)) u_yn_dly (
      .clock (clock), .en (en), .d (yn), .q (yn_d)
   );
   cpp_qmul u_xnrf (.clock(clock), .en(en), .a(xn_d), .b(rf_ff), .p(xnrf));
   cpp_qmul u_ynrf (.clock(clock), .en(en), .a(yn_d), .b(rf_ff), .p(ynrf));

   // focal scaling
   cpp_qmul u_fxxd (.clock(clock), .en(en), .a(fx), .b(xd_ff), .p(fxxd));
   cpp_qmul u_fyyd (.clock(clock), .en(en), .a(fy), .b(yd_ff), .p(fyyd));

   // saturating adds between the multiplier stages
   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff  <= sadd(x2, y2);
         tx2_ff <= sadd(x2, x2);
         ty2_ff <= sadd(y2, y2);
         ux_ff  <= sadd(r2_ff, tx2_ff);
         uy_ff  <= sadd(r2_ff, ty2_ff);
         s1_ff  <= sadd(Q24_ONE, k1r2);
         s2_ff  <= sadd(k2r4_d, k3r6);
         rf_ff  <= sadd(s1_d, s2_ff);
         xt_ff  <= sadd(p1xy_d, p2ux);
         yt_ff  <= sadd(p1uy, p2xy_d);
         xd_ff  <= sadd(xnrf, xt_d);
         yd_ff  <= sadd(ynrf, yt_d);
         px_ff  <= sat32(sadd(fxxd, cx));
         py_ff  <= sat32(sadd(fyyd, cy));
         ok_ff  <= fov_ok_d;
      end
   end

   assign rsp_tdata = {py_ff, px_ff};
   assign rsp_tuser = ok_ff;

endmodule

`default_nettype wire
